>>> sv/trs_pkg.sv
// Shared types and constants for the token ring station.
package trs_pkg;

	// Width of the counter fields on the result port
	localparam int unsigned CNT_OUT_W = 16;

	// Ring byte codes
	localparam logic [7:0] FREE_TOKEN = 8'h00;
	localparam logic [7:0] BUSY_FLAG  = 8'h01;

	// Input word actions
	typedef enum logic [1:0] {
		ACT_RING  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_POST  = 2'd2,
		ACT_START = 2'd3
	} action_t;

	// Receive side: where in a passing frame we are
	typedef enum logic [2:0] {
		RX_FLAG = 3'd0,
		RX_TO   = 3'd1,
		RX_FROM = 3'd2,
		RX_LEN  = 3'd3,
		RX_DATA = 3'd4
	} rx_phase_t;

	// Transmit side: next byte of our own frame
	typedef enum logic [2:0] {
		TX_IDLE  = 3'd0,
		TX_DEST  = 3'd1,
		TX_SRC   = 3'd2,
		TX_LEN   = 3'd3,
		TX_DATA  = 3'd4,
		TX_TOKEN = 3'd5
	} tx_phase_t;

endpackage

>>> sv/token_ring_station.sv
// Top level of the byte-wide token ring station.
//
// One input word is taken every clock cycle; a result word (for ring bytes and
// the start action) passes through the read stage, which reads the transmit
// buffer, and the output register. Frame control state is updated in the cycle
// a word is accepted, so words can follow each other without gaps; only a
// stalled output slows the input, once both the read stage and the output
// register hold a word. The transmit buffer is a RAM with no reset: entries
// must be written before a frame that sends them is posted. The user writes the
// station address through the cfg port while idle; the block does not check.
module token_ring_station
	import trs_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = 256,
	parameter int unsigned COUNT_WIDTH  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [7:0]           cfg_data,
	// input words
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  logic [7:0]           byte_value,
	input  logic [7:0]           write_index,
	input  logic [7:0]           dest_address,
	input  logic [7:0]           data_length,
	// result words
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           ring_out,
	output logic [CNT_OUT_W-1:0] frames_received,
	output logic [CNT_OUT_W-1:0] frames_sent,
	output logic                 packet_pending
);

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);

	// Buffer position of a byte-wide index, as a constant lookup
	function automatic logic [AW-1:0] buf_idx(input logic [7:0] v);
		logic [AW-1:0] r;
		r = '0;
		for (int i = 0; i < 256; i++) begin
			if (v == 8'(i)) begin
				r = AW'(i % BUFFER_DEPTH);
			end
		end
		return r;
	endfunction

	// Control state
	logic [7:0]             addr_q;
	rx_phase_t              rx_ph_q,  nxt_rx_ph;
	tx_phase_t              tx_ph_q,  nxt_tx_ph;
	logic [7:0]             flen_q,   nxt_flen;
	logic [7:0]             fpos_q,   nxt_fpos;
	logic [7:0]             tx_pos_q, nxt_tx_pos;
	logic                   pend_q,   nxt_pend;
	logic [7:0]             pdest_q,  nxt_pdest;
	logic [7:0]             plen_q,   nxt_plen;
	logic [COUNT_WIDTH-1:0] rx_cnt_q, nxt_rx_cnt;
	logic [COUNT_WIDTH-1:0] tx_cnt_q, nxt_tx_cnt;

	// Read stage
	logic                   valid_s1;
	logic                   use_ram_s1;
	logic [7:0]             ring_s1;
	logic [CNT_OUT_W-1:0]   rx_cnt_s1;
	logic [CNT_OUT_W-1:0]   tx_cnt_s1;
	logic                   pend_s1;

	// Output register
	logic                   out_valid_q;
	logic [7:0]             ring_q;
	logic [CNT_OUT_W-1:0]   rx_out_q;
	logic [CNT_OUT_W-1:0]   tx_out_q;
	logic                   pend_out_q;

	action_t                act;
	logic                   acc;
	logic                   has_result;
	logic                   adv_s1;
	logic [7:0]             ring_c;
	logic                   use_ram_c;
	logic                   ram_we;
	logic                   ram_re;
	logic [7:0]             ram_rdata;

	assign act        = action_t'(action);
	assign acc        = in_valid && in_ready;
	assign has_result = (act == ACT_RING) || (act == ACT_START);
	assign adv_s1     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || adv_s1;
	assign cfg_ready  = 1'b1;

	// Transmit buffer
	assign ram_we = acc && (act == ACT_WRITE);
	assign ram_re = acc && (act == ACT_RING) && (tx_ph_q == TX_DATA);

	trs_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_tx_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (buf_idx(write_index)),
		.wdata (byte_value),
		.re    (ram_re),
		.raddr (buf_idx(tx_pos_q)),
		.rdata (ram_rdata)
	);

	// Step of the station for the word at the input
	always_comb begin
		nxt_rx_ph  = rx_ph_q;
		nxt_tx_ph  = tx_ph_q;
		nxt_flen   = flen_q;
		nxt_fpos   = fpos_q;
		nxt_tx_pos = tx_pos_q;
		nxt_pend   = pend_q;
		nxt_pdest  = pdest_q;
		nxt_plen   = plen_q;
		nxt_rx_cnt = rx_cnt_q;
		nxt_tx_cnt = tx_cnt_q;
		ring_c     = byte_value;
		use_ram_c  = 1'b0;
		unique case (act)
			ACT_WRITE: begin
				// buffer write only, handled by the RAM port
			end
			ACT_POST: begin
				if (!pend_q) begin
					nxt_pend  = 1'b1;
					nxt_pdest = dest_address;
					nxt_plen  = data_length;
				end
			end
			ACT_START: begin
				ring_c = FREE_TOKEN;
			end
			ACT_RING: begin
				if (tx_ph_q != TX_IDLE) begin
					// own frame: incoming byte stripped
					unique case (tx_ph_q)
						TX_DEST: begin
							ring_c    = pdest_q;
							nxt_tx_ph = TX_SRC;
						end
						TX_SRC: begin
							ring_c    = addr_q;
							nxt_tx_ph = TX_LEN;
						end
						TX_LEN: begin
							ring_c     = plen_q;
							nxt_tx_pos = '0;
							nxt_tx_ph  = (plen_q != 8'd0) ? TX_DATA : TX_TOKEN;
						end
						TX_DATA: begin
							use_ram_c  = 1'b1;
							nxt_tx_pos = tx_pos_q + 8'd1;
							if (nxt_tx_pos == plen_q) begin
								nxt_tx_ph = TX_TOKEN;
							end
						end
						default: begin
							// closing token ends the transmission
							ring_c     = FREE_TOKEN;
							nxt_tx_cnt = tx_cnt_q + 1'b1;
							nxt_pend   = 1'b0;
							nxt_tx_pos = '0;
							nxt_tx_ph  = TX_IDLE;
							nxt_rx_ph  = RX_FLAG;
						end
					endcase
				end else begin
					// repeat mode: byte passed on
					unique case (rx_ph_q)
						RX_TO: begin
							if (byte_value == addr_q) begin
								nxt_rx_cnt = rx_cnt_q + 1'b1;
							end
							nxt_rx_ph = RX_FROM;
						end
						RX_FROM: begin
							nxt_rx_ph = RX_LEN;
						end
						RX_LEN: begin
							nxt_flen  = byte_value;
							nxt_fpos  = '0;
							nxt_rx_ph = (byte_value != 8'd0) ? RX_DATA : RX_FLAG;
						end
						RX_DATA: begin
							nxt_fpos = fpos_q + 8'd1;
							if (nxt_fpos == flen_q) begin
								nxt_rx_ph = RX_FLAG;
							end
						end
						default: begin
							nxt_rx_ph = RX_FLAG;
							if (byte_value != FREE_TOKEN) begin
								nxt_rx_ph = RX_TO;
							end else if (pend_q) begin
								// seize the token
								ring_c    = BUSY_FLAG;
								nxt_tx_ph = TX_DEST;
							end
						end
					endcase
				end
			end
		endcase
	end

	// Station address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			addr_q <= cfg_data;
		end
	end

	// Frame control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ph_q  <= RX_FLAG;
			tx_ph_q  <= TX_IDLE;
			flen_q   <= '0;
			fpos_q   <= '0;
			tx_pos_q <= '0;
			pend_q   <= 1'b0;
			pdest_q  <= '0;
			plen_q   <= '0;
			rx_cnt_q <= '0;
			tx_cnt_q <= '0;
		end else if (acc) begin
			rx_ph_q  <= nxt_rx_ph;
			tx_ph_q  <= nxt_tx_ph;
			flen_q   <= nxt_flen;
			fpos_q   <= nxt_fpos;
			tx_pos_q <= nxt_tx_pos;
			pend_q   <= nxt_pend;
			pdest_q  <= nxt_pdest;
			plen_q   <= nxt_plen;
			rx_cnt_q <= nxt_rx_cnt;
			tx_cnt_q <= nxt_tx_cnt;
		end
	end

	// Read stage: waits for the buffer data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc && has_result) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && has_result) begin
			use_ram_s1 <= use_ram_c;
			ring_s1    <= ring_c;
			rx_cnt_s1  <= CNT_OUT_W'(nxt_rx_cnt);
			tx_cnt_s1  <= CNT_OUT_W'(nxt_tx_cnt);
			pend_s1    <= nxt_pend;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ring_q     <= use_ram_s1 ? ram_rdata : ring_s1;
			rx_out_q   <= rx_cnt_s1;
			tx_out_q   <= tx_cnt_s1;
			pend_out_q <= pend_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign ring_out        = ring_q;
	assign frames_received = rx_out_q;
	assign frames_sent     = tx_out_q;
	assign packet_pending  = pend_out_q;

	// A transmission only runs for a posted packet
	a_tx_needs_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_ph_q != TX_IDLE) |-> pend_q)
		else $error("transmit phase active without a pending packet");

	// Pending clears only together with a sent-frame count
	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pend_q) |-> (tx_cnt_q == COUNT_WIDTH'($past(tx_cnt_q) + 1'b1)))
		else $error("pending flag cleared without counting a sent frame");

	// Buffer data for a stalled read stage must not move
	a_rdata_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && use_ram_s1 && !adv_s1) |=> $stable(ram_rdata))
		else $error("buffer read data changed under a stalled read stage");

endmodule

>>> sv/trs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module trs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
